// File: sv/ogu_pkg.sv
// ----------------------------------------------------------------------------
// ogu_pkg: shared types and constants for the occupancy grid cell updater
// Payload structs of the item channels, register indexes, fixed-point
// constants and the per-lane model configuration.
// ----------------------------------------------------------------------------
package ogu_pkg;

    localparam int MAP_CELLS_DEF = 65536;
    localparam int BEAMS_DEF     = 3;
    localparam int BEAM_INPUTS   = 3;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_PROB    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PROB   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIOR_PROB  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OCC_THRESH  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_HALF   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PLATEAU_END = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_END    = 4'd7;

    localparam logic [15:0] LOW_PROB_RST    = 16'd19661;
    localparam logic [15:0] HIGH_PROB_RST   = 16'd45875;
    localparam logic [15:0] PRIOR_PROB_RST  = 16'd32768;
    localparam logic [14:0] OCC_THRESH_RST  = 15'd4500;
    localparam logic [15:0] MAX_RANGE_RST   = 16'd50000;
    localparam logic [9:0]  RISE_HALF_RST   = 10'd50;
    localparam logic [10:0] PLATEAU_END_RST = 11'd150;
    localparam logic [10:0] TAIL_END_RST    = 11'd200;

    // Q3.12 log-odds limits: logit(0.1), logit(0.9), logit(0.3)
    localparam logic signed [14:0] LOGODDS_MIN   = -15'sd9000;
    localparam logic signed [14:0] LOGODDS_MAX   = 15'sd9000;
    localparam logic signed [14:0] LOGODDS_RESET = -15'sd3470;

    localparam logic [15:0] LN2_Q16 = 16'd45426;

    // divide by three: (x * RECIP_THIRD) >> AVG_SHIFT, exact for x < 2^19
    localparam int          AVG_SHIFT   = 19;
    localparam logic [17:0] RECIP_THIRD = 18'd174763;

    typedef struct packed {
        logic [15:0] cell_index;
        logic [15:0] cell_range_mm;
        logic [1:0]  beam_count;
        logic [15:0] beam_range_a;
        logic [15:0] beam_range_b;
        logic [15:0] beam_range_c;
    } in_item_t;

    typedef struct packed {
        logic [15:0] cell_index_out;
        logic [14:0] new_logodds;
        logic        occupied;
        logic        was_updated;
        logic [15:0] model_prob;
    } out_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [15:0]          wdata;
    } cfg_item_t;

    typedef struct packed {
        logic [15:0] low_prob;
        logic [15:0] high_prob;
        logic [15:0] prior_prob;
        logic [15:0] max_range_mm;
        logic [9:0]  rise_half_width_mm;
        logic [10:0] plateau_end_mm;
        logic [10:0] tail_end_mm;
    } lane_cfg_t;

endpackage

// File: sv/ogu_stream_if.sv
// ----------------------------------------------------------------------------
// ogu_stream_if: valid/ready item channel
// Carries one payload item per handshake; source and sink views.
// ----------------------------------------------------------------------------
interface ogu_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/ogu_ram.sv
// ----------------------------------------------------------------------------
// ogu_ram: simple dual-port RAM
// One write port, one read port, registered read (old data on collision).
// ----------------------------------------------------------------------------
module ogu_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/ogu_beam_lane.sv
// ----------------------------------------------------------------------------
// ogu_beam_lane: inverse sensor model for one beam
// Segment select, one interpolation multiply, 16-stage restoring divider.
// ----------------------------------------------------------------------------
module ogu_beam_lane (
    input  logic              clk,
    input  logic              en,
    input  ogu_pkg::lane_cfg_t cfg,
    input  logic [15:0]       cell_range,
    input  logic [15:0]       beam_range,
    output logic [15:0]       prob
);

    localparam int DIV_STEPS = 16;

    logic signed [17:0] rr, zz, b1, b2, b3, b4;
    logic signed [16:0] delta;
    logic [15:0]        base_a;
    logic [15:0]        dmag_a;
    logic [11:0]        t_a;
    logic [11:0]        den_a;

    logic [15:0] base_s1_reg;
    logic        neg_s1_reg;
    logic [15:0] dmag_s1_reg;
    logic [11:0] t_s1_reg;
    logic [11:0] den_s1_reg;

    logic [27:0] prod;

    logic [11:0] rem_reg  [DIV_STEPS+1];
    logic [15:0] num_reg  [DIV_STEPS+1];
    logic [15:0] quo_reg  [DIV_STEPS+1];
    logic [15:0] base_reg [DIV_STEPS+1];
    logic        neg_reg  [DIV_STEPS+1];
    logic [11:0] den_reg  [DIV_STEPS+1];

    logic [11:0] rem_next [DIV_STEPS+1];
    logic        qbit     [DIV_STEPS+1];

    logic [15:0] prob_reg;

    // segment select
    always_comb
    begin
        rr    = $signed({2'b00, cell_range});
        zz    = $signed({2'b00, beam_range});
        b1    = zz - $signed({8'd0, cfg.rise_half_width_mm});
        b2    = zz + $signed({8'd0, cfg.rise_half_width_mm});
        b3    = zz + $signed({7'd0, cfg.plateau_end_mm});
        b4    = zz + $signed({7'd0, cfg.tail_end_mm});
        delta = '0;
        t_a   = '0;
        den_a = 12'd1;
        base_a = cfg.low_prob;
        priority if (beam_range >= cfg.max_range_mm || rr < b1)
        begin
            base_a = cfg.low_prob;
        end
        else if (rr <= b2)
        begin
            if (cfg.rise_half_width_mm == '0)
            begin
                base_a = cfg.high_prob;
            end
            else
            begin
                base_a = cfg.low_prob;
                delta  = $signed({1'b0, cfg.high_prob}) - $signed({1'b0, cfg.low_prob});
                t_a    = 12'(rr - b1);
                den_a  = {1'b0, cfg.rise_half_width_mm, 1'b0};
            end
        end
        else if (rr <= b3)
        begin
            base_a = cfg.high_prob;
        end
        else if (rr <= b4)
        begin
            // fall from plateau toward prior; tail is past plateau here
            base_a = cfg.high_prob;
            delta  = $signed({1'b0, cfg.prior_prob}) - $signed({1'b0, cfg.high_prob});
            t_a    = 12'(rr - b3);
            den_a  = {1'b0, cfg.tail_end_mm} - {1'b0, cfg.plateau_end_mm};
        end
        else
        begin
            base_a = cfg.prior_prob;
        end
        dmag_a = (delta < 0) ? 16'(-delta) : 16'(delta);
    end

    assign prod = 28'(dmag_s1_reg) * 28'(t_s1_reg);

    // one quotient bit per stage; remainder always below the divisor
    always_comb
    begin
        rem_next[0] = '0;
        qbit[0]     = 1'b0;
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            if ({rem_reg[k-1], num_reg[k-1][15]} >= {1'b0, den_reg[k-1]})
            begin
                qbit[k]     = 1'b1;
                rem_next[k] = 12'({rem_reg[k-1], num_reg[k-1][15]} - {1'b0, den_reg[k-1]});
            end
            else
            begin
                qbit[k]     = 1'b0;
                rem_next[k] = {rem_reg[k-1][10:0], num_reg[k-1][15]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            base_s1_reg <= base_a;
            neg_s1_reg  <= delta < 0;
            dmag_s1_reg <= dmag_a;
            t_s1_reg    <= t_a;
            den_s1_reg  <= den_a;

            rem_reg[0]  <= prod[27:16];
            num_reg[0]  <= prod[15:0];
            quo_reg[0]  <= '0;
            base_reg[0] <= base_s1_reg;
            neg_reg[0]  <= neg_s1_reg;
            den_reg[0]  <= den_s1_reg;

            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                num_reg[k]  <= {num_reg[k-1][14:0], 1'b0};
                quo_reg[k]  <= {quo_reg[k-1][14:0], qbit[k]};
                base_reg[k] <= base_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
            end

            prob_reg <= neg_reg[DIV_STEPS] ? base_reg[DIV_STEPS] - quo_reg[DIV_STEPS]
                                           : base_reg[DIV_STEPS] + quo_reg[DIV_STEPS];
        end
    end

    assign prob = prob_reg;

endmodule

// File: sv/ogu_logit.sv
// ----------------------------------------------------------------------------
// ogu_logit: Q0.16 probability to Q5.12 log-odds
// log2 of p and 1-p by 16 pipelined squaring stages, then ln2 scaling.
// ----------------------------------------------------------------------------
module ogu_logit (
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        prob,
    output logic signed [16:0] logodds
);

    localparam int SQ_STEPS = 16;

    function automatic logic [3:0] lead_one(input logic [15:0] x);
        logic [3:0] m;
        m = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (x[i])
            begin
                m = 4'(i);
            end
        end
        return m;
    endfunction

    logic [15:0] p_clamped;
    logic [15:0] q_val;
    logic [3:0]  mp, mq;

    logic [30:0] yp_reg [SQ_STEPS+1];
    logic [30:0] yq_reg [SQ_STEPS+1];
    logic [15:0] fp_reg [SQ_STEPS+1];
    logic [15:0] fq_reg [SQ_STEPS+1];
    logic [3:0]  mp_reg [SQ_STEPS+1];
    logic [3:0]  mq_reg [SQ_STEPS+1];

    logic [31:0] tp [SQ_STEPS+1];
    logic [31:0] tq [SQ_STEPS+1];

    logic signed [4:0]  dm;
    logic signed [21:0] d;
    logic               neg_reg, neg2_reg;
    logic [20:0]        mag_reg;
    logic [36:0]        prod_reg;
    logic [15:0]        rmag;
    logic signed [16:0] logodds_reg;

    always_comb
    begin
        p_clamped = (prob == '0) ? 16'd1 : prob;
        q_val     = 16'(17'h10000 - {1'b0, p_clamped});
        mp        = lead_one(p_clamped);
        mq        = lead_one(q_val);
    end

    always_comb
    begin
        tp[0] = '0;
        tq[0] = '0;
        for (int k = 1; k <= SQ_STEPS; k++)
        begin
            tp[k] = 32'((62'(yp_reg[k-1]) * 62'(yp_reg[k-1])) >> 30);
            tq[k] = 32'((62'(yq_reg[k-1]) * 62'(yq_reg[k-1])) >> 30);
        end
    end

    always_comb
    begin
        dm   = $signed({1'b0, mp_reg[SQ_STEPS]}) - $signed({1'b0, mq_reg[SQ_STEPS]});
        d    = $signed({dm[4], dm, 16'd0}) + $signed({6'd0, fp_reg[SQ_STEPS]})
             - $signed({6'd0, fq_reg[SQ_STEPS]});
        rmag = 16'((prod_reg + 37'd524288) >> 20);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yp_reg[0] <= 31'(p_clamped) << (5'd30 - {1'b0, mp});
            yq_reg[0] <= 31'(q_val) << (5'd30 - {1'b0, mq});
            fp_reg[0] <= '0;
            fq_reg[0] <= '0;
            mp_reg[0] <= mp;
            mq_reg[0] <= mq;
            for (int k = 1; k <= SQ_STEPS; k++)
            begin
                yp_reg[k] <= tp[k][31] ? tp[k][31:1] : tp[k][30:0];
                yq_reg[k] <= tq[k][31] ? tq[k][31:1] : tq[k][30:0];
                fp_reg[k] <= {fp_reg[k-1][14:0], tp[k][31]};
                fq_reg[k] <= {fq_reg[k-1][14:0], tq[k][31]};
                mp_reg[k] <= mp_reg[k-1];
                mq_reg[k] <= mq_reg[k-1];
            end
            neg_reg     <= d[21];
            mag_reg     <= d[21] ? 21'(-d) : 21'(d);
            neg2_reg    <= neg_reg;
            prod_reg    <= 37'(mag_reg) * 37'(ogu_pkg::LN2_Q16);
            logodds_reg <= neg2_reg ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
        end
    end

    assign logodds = logodds_reg;

endmodule

// File: sv/occupancy_grid_logodds_update.sv
// ----------------------------------------------------------------------------
// occupancy_grid_logodds_update: occupancy grid cell log-odds updater
// Throughput: one item per cycle while the output is not stalled and the
//   store is not clearing; lane dividers and logit squarers are fully
//   pipelined, the cell store does one read and one write per cycle.
// Reset: registers take their defaults; the cell store is then swept to
//   logit(0.3), one cell per cycle, with in_ch.ready low.
// ----------------------------------------------------------------------------
module occupancy_grid_logodds_update #(
    parameter int MAP_CELLS      = ogu_pkg::MAP_CELLS_DEF,
    parameter int BEAMS_PER_CELL = ogu_pkg::BEAMS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    ogu_stream_if.sink   in_ch,
    ogu_stream_if.source out_ch,
    ogu_stream_if.sink   cfg_ch
);

    localparam int ADDR_W = $clog2(MAP_CELLS);
    localparam int LANES  = (BEAMS_PER_CELL < ogu_pkg::BEAM_INPUTS) ? BEAMS_PER_CELL
                                                                   : ogu_pkg::BEAM_INPUTS;
    localparam logic [1:0] CNT_CAP = 2'(LANES);

    // stage positions along the item tag line
    localparam int LANE_LAT  = 19;
    localparam int SUM_POS   = LANE_LAT;
    localparam int AVG_POS   = SUM_POS + 1;
    localparam int LOGIT_LAT = 20;
    localparam int LAST      = AVG_POS + LOGIT_LAT;
    localparam int TAG_N     = LAST + 1;

    // floor reciprocal for cell index modulo; one correction step suffices
    localparam longint unsigned MOD_RECIP = (64'd1 << 32) / MAP_CELLS;

    // ---------------- configuration registers ----------------
    ogu_pkg::lane_cfg_t lane_cfg_reg;
    logic signed [14:0] thresh_reg;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_cfg_reg.low_prob           <= ogu_pkg::LOW_PROB_RST;
            lane_cfg_reg.high_prob          <= ogu_pkg::HIGH_PROB_RST;
            lane_cfg_reg.prior_prob         <= ogu_pkg::PRIOR_PROB_RST;
            lane_cfg_reg.max_range_mm       <= ogu_pkg::MAX_RANGE_RST;
            lane_cfg_reg.rise_half_width_mm <= ogu_pkg::RISE_HALF_RST;
            lane_cfg_reg.plateau_end_mm     <= ogu_pkg::PLATEAU_END_RST;
            lane_cfg_reg.tail_end_mm        <= ogu_pkg::TAIL_END_RST;
            thresh_reg                      <= ogu_pkg::OCC_THRESH_RST;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.data.reg_index)
                ogu_pkg::CFG_LOW_PROB:    lane_cfg_reg.low_prob <= cfg_ch.data.wdata;
                ogu_pkg::CFG_HIGH_PROB:   lane_cfg_reg.high_prob <= cfg_ch.data.wdata;
                ogu_pkg::CFG_PRIOR_PROB:  lane_cfg_reg.prior_prob <= cfg_ch.data.wdata;
                ogu_pkg::CFG_OCC_THRESH:  thresh_reg <= $signed(cfg_ch.data.wdata[14:0]);
                ogu_pkg::CFG_MAX_RANGE:   lane_cfg_reg.max_range_mm <= cfg_ch.data.wdata;
                ogu_pkg::CFG_RISE_HALF:
                    lane_cfg_reg.rise_half_width_mm <= cfg_ch.data.wdata[9:0];
                ogu_pkg::CFG_PLATEAU_END: lane_cfg_reg.plateau_end_mm <= cfg_ch.data.wdata[10:0];
                ogu_pkg::CFG_TAIL_END:    lane_cfg_reg.tail_end_mm <= cfg_ch.data.wdata[10:0];
                default: ;
            endcase
        end
    end

    // ---------------- clearing sweep after reset ----------------
    logic              clr_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(MAP_CELLS - 1))
            begin
                clr_reg <= 1'b0;
            end
        end
    end

    // ---------------- global pipeline advance ----------------
    // the whole pipeline moves when the output register is free or drained
    logic en;
    logic in_acc;
    logic out_vld_reg;

    assign en          = !out_vld_reg || out_ch.ready;
    assign in_ch.ready = en && !clr_reg;
    assign in_acc      = in_ch.valid && in_ch.ready;

    logic [1:0] cnt_in;
    assign cnt_in = (in_ch.data.beam_count > CNT_CAP) ? CNT_CAP : in_ch.data.beam_count;

    // ---------------- item tag line ----------------
    logic              vld_reg  [TAG_N];
    logic [15:0]       idx_reg  [TAG_N];
    logic [1:0]        cnt_reg  [TAG_N];
    logic [ADDR_W-1:0] addr_tag_reg [2:LAST];
    logic [15:0]       prob_tag_reg [AVG_POS:LAST];
    logic [47:0]       modprod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TAG_N; k++)
            begin
                vld_reg[k] <= 1'b0;
                cnt_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_acc;
            cnt_reg[0] <= cnt_in;
            for (int k = 1; k < TAG_N; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
                cnt_reg[k] <= cnt_reg[k-1];
            end
        end
    end

    // cell index modulo MAP_CELLS: reciprocal multiply, then one correction
    logic [15:0] mod_quo;
    logic [31:0] mod_qm;
    logic [15:0] mod_rem;
    logic [15:0] mod_fix;

    always_comb
    begin
        mod_quo = modprod_reg[47:32];
        mod_qm  = 32'(mod_quo) * 32'(MAP_CELLS);
        mod_rem = idx_reg[1] - mod_qm[15:0];
        mod_fix = (32'(mod_rem) >= 32'(MAP_CELLS)) ? mod_rem - 16'(MAP_CELLS) : mod_rem;
    end

    // ---------------- beam lanes ----------------
    logic [15:0] beam_in   [ogu_pkg::BEAM_INPUTS];
    logic [15:0] lane_prob [LANES];

    assign beam_in[0] = in_ch.data.beam_range_a;
    assign beam_in[1] = in_ch.data.beam_range_b;
    assign beam_in[2] = in_ch.data.beam_range_c;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        ogu_beam_lane u_lane (
            .clk        (clk),
            .en         (en),
            .cfg        (lane_cfg_reg),
            .cell_range (in_ch.data.cell_range_mm),
            .beam_range (beam_in[i]),
            .prob       (lane_prob[i])
        );
    end

    // ---------------- merge: sum, rounded average ----------------
    logic [17:0] sum_next;
    logic [17:0] sum_reg;
    logic [35:0] prod3;
    logic [17:0] avg_wide;
    logic [15:0] avg_next;

    always_comb
    begin
        sum_next = 18'(cnt_reg[LANE_LAT-1] >> 1);
        for (int i = 0; i < LANES; i++)
        begin
            if (2'(i) < cnt_reg[LANE_LAT-1])
            begin
                sum_next = sum_next + 18'(lane_prob[i]);
            end
        end
    end

    always_comb
    begin
        prod3 = 36'(sum_reg) * 36'(ogu_pkg::RECIP_THIRD);
        unique case (cnt_reg[SUM_POS])
            2'd0: avg_wide = '0;
            2'd1: avg_wide = sum_reg;
            2'd2: avg_wide = sum_reg >> 1;
            2'd3: avg_wide = 18'(prod3 >> ogu_pkg::AVG_SHIFT);
        endcase
        avg_next = (avg_wide > 18'd65535) ? 16'hFFFF : avg_wide[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx_reg[0] <= in_ch.data.cell_index;
            for (int k = 1; k < TAG_N; k++)
            begin
                idx_reg[k] <= idx_reg[k-1];
            end
            modprod_reg     <= 48'(idx_reg[0]) * 48'(MOD_RECIP);
            addr_tag_reg[2] <= ADDR_W'(mod_fix);
            for (int k = 3; k <= LAST; k++)
            begin
                addr_tag_reg[k] <= addr_tag_reg[k-1];
            end
            sum_reg               <= sum_next;
            prob_tag_reg[AVG_POS] <= avg_next;
            for (int k = AVG_POS + 1; k <= LAST; k++)
            begin
                prob_tag_reg[k] <= prob_tag_reg[k-1];
            end
        end
    end

    // ---------------- logit ----------------
    logic signed [16:0] logit_val;

    ogu_logit u_logit (
        .clk     (clk),
        .en      (en),
        .prob    (prob_tag_reg[AVG_POS]),
        .logodds (logit_val)
    );

    // ---------------- cell store, read-modify-write ----------------
    // Read is issued one stage ahead; while stalled the read repeats for the
    // item in the update stage so its data stays current. The last write is
    // forwarded to cover the read that collided with it.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [14:0]       ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [14:0]       ram_rdata;

    logic              fwd_vld_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic signed [14:0] fwd_data_reg;

    logic signed [14:0] stored;
    logic signed [17:0] acc;
    logic signed [14:0] sat_lo;
    logic signed [14:0] new_lo;
    logic               upd;
    logic               wr;

    assign ram_raddr = en ? addr_tag_reg[LAST-1] : addr_tag_reg[LAST];

    always_comb
    begin
        stored = (fwd_vld_reg && fwd_addr_reg == addr_tag_reg[LAST]) ? fwd_data_reg
                                                                     : $signed(ram_rdata);
        acc    = $signed({{3{stored[14]}}, stored}) + $signed({logit_val[16], logit_val});
        if (acc < 18'(ogu_pkg::LOGODDS_MIN))
        begin
            sat_lo = ogu_pkg::LOGODDS_MIN;
        end
        else if (acc > 18'(ogu_pkg::LOGODDS_MAX))
        begin
            sat_lo = ogu_pkg::LOGODDS_MAX;
        end
        else
        begin
            sat_lo = acc[14:0];
        end
        upd    = cnt_reg[LAST] != 2'd0;
        new_lo = upd ? sat_lo : stored;
        wr     = en && vld_reg[LAST] && upd;
    end

    assign ram_we    = clr_reg || wr;
    assign ram_waddr = clr_reg ? clr_addr_reg : addr_tag_reg[LAST];
    assign ram_wdata = clr_reg ? ogu_pkg::LOGODDS_RESET : new_lo;

    ogu_ram #(
        .WIDTH (15),
        .DEPTH (MAP_CELLS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_vld_reg <= 1'b0;
        end
        else if (wr)
        begin
            fwd_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            fwd_addr_reg <= addr_tag_reg[LAST];
            fwd_data_reg <= new_lo;
        end
    end

    // ---------------- output register ----------------
    ogu_pkg::out_item_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vld_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg.cell_index_out <= idx_reg[LAST];
            out_data_reg.new_logodds    <= new_lo;
            out_data_reg.occupied       <= new_lo > thresh_reg;
            out_data_reg.was_updated    <= upd;
            out_data_reg.model_prob     <= prob_tag_reg[LAST];
        end
    end

    assign out_ch.valid = out_vld_reg;
    assign out_ch.data  = out_data_reg;

    // ---------------- checks ----------------
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !in_ch.ready)
        else $error("item accepted during store clearing");

    a_clear_runs_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_reg |=> !clr_reg)
        else $error("store clearing restarted");

    a_logodds_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> ($signed(out_data_reg.new_logodds) >= ogu_pkg::LOGODDS_MIN
                      && $signed(out_data_reg.new_logodds) <= ogu_pkg::LOGODDS_MAX))
        else $error("log-odds result outside saturation limits");

    a_idle_prob_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_data_reg.was_updated) |-> out_data_reg.model_prob == 16'd0)
        else $error("model probability nonzero on a non-updating item");

endmodule
